// ----- hdl/i2a_pkg.sv -----
// Shared types, constants and helper functions of the integer to ASCII digit converter.
package i2a_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CharW    = 8;
  localparam int unsigned BcdDigs  = 20;
  localparam int unsigned BcdW     = 4 * BcdDigs;
  localparam int unsigned ConvCycW = 5;

  localparam logic [CountW-1:0]   MaxDigits    = 5'd22;
  localparam logic [ConvCycW-1:0] ConvLastCyc  = 5'd31;
  localparam logic [CharW-1:0]    CharZero     = 8'h30;
  localparam logic [CharW-1:0]    CharTerm     = 8'h00;
  localparam logic [CharW-1:0]    HexLowerOffs = 8'd49;
  localparam logic [CharW-1:0]    HexUpperOffs = 8'd17;

  // Request type codes on the input channel.
  localparam logic [1:0] ReqUdec = 2'd0;
  localparam logic [1:0] ReqSdec = 2'd1;
  localparam logic [1:0] ReqOct  = 2'd2;
  localparam logic [1:0] ReqHex  = 2'd3;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    radix_e              radix;
    logic [ValueW-1:0]   mag;
    logic [CountW-1:0]   count;
    logic                lower;
  } req_t;

  // One double-dabble step: correct every BCD digit, then shift in one bit.
  function automatic logic [BcdW-1:0] dd_step(input logic [BcdW-1:0] bcd, input logic b);
    logic [BcdW-1:0] corr;
    corr = bcd;
    for (int k = 0; k < BcdDigs; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        corr[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
    return {corr[BcdW-2:0], b};
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic lower);
    logic [CharW-1:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CharZero + d8;
    end
    return CharZero + (lower ? HexLowerOffs : HexUpperOffs) + (d8 - 8'd10);
  endfunction

endpackage

// ----- hdl/integer_to_ascii_digits.sv -----
// Top level of the integer to ASCII digit converter.
// Converts a 64-bit value into digit_count ASCII digits in unsigned decimal,
// signed decimal (magnitude only), octal or hexadecimal. A request enters on
// the in_* channel; results leave on the out_* channel least significant
// digit first, each with its buffer position, followed by a terminator
// transaction with character zero at position digit_count and last set.
// Counts above 22 are clamped to 22.
// A front end classifies requests into a two-entry queue, so up to two
// requests are taken while the back end is busy. The back end handles one
// request at a time: decimal requests first run a double-dabble pass that
// converts two bits per cycle before any digit leaves, while octal and hex
// digits are taken straight from the magnitude. Each result is registered in
// the output register; after the first, one result leaves per cycle while
// out_ready_i is high.
// When the receiver stalls, the output register holds its transaction and the
// back end waits; the queue keeps accepting until it is full.
// Reset empties the queue and the output register.
module integer_to_ascii_digits import i2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [CountW-1:0] digit_count_i,
  input  logic              lower_case_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  character_o,
  output logic [CountW-1:0] position_o,
  output logic              last_o
);

  req_t fr_req, bk_req;
  logic push, full, q_valid, pop;

  i2a_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .lower_case_i  (lower_case_i),
    .push_o        (push),
    .full_i        (full),
    .req_o         (fr_req)
  );

  i2a_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fr_req),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (bk_req)
  );

  i2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (bk_req),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

endmodule

// ----- hdl/i2a_front.sv -----
// Front end: classifies a request into radix, magnitude and clamped digit count.
module i2a_front import i2a_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [CountW-1:0] digit_count_i,
  input  logic              lower_case_i,
  output logic              push_o,
  input  logic              full_i,
  output req_t              req_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    req_o.mag   = value_i;
    req_o.lower = 1'b0;
    req_o.count = (digit_count_i > MaxDigits) ? MaxDigits : digit_count_i;
    case (req_type_i)
      ReqUdec: req_o.radix = RADIX_DEC;
      ReqSdec: begin
        req_o.radix = RADIX_DEC;
        // Negative values convert through their magnitude; no sign is emitted.
        if (value_i[ValueW-1]) begin
          req_o.mag = ~value_i + {{(ValueW-1){1'b0}}, 1'b1};
        end
      end
      ReqOct:  req_o.radix = RADIX_OCT;
      ReqHex: begin
        req_o.radix = RADIX_HEX;
        req_o.lower = lower_case_i;
      end
      default: req_o.radix = RADIX_DEC;
    endcase
  end

endmodule

// ----- hdl/i2a_fifo.sv -----
// Two-entry request queue between the front end and the back end.
module i2a_fifo import i2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t wdata_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output req_t rdata_o
);

  req_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- hdl/i2a_back.sv -----
// Back end: decimal conversion by double dabble, digit sequencing and the output register.
module i2a_back import i2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  req_t              req_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  character_o,
  output logic [CountW-1:0] position_o,
  output logic              last_o
);

  state_e               state_q, state_d;
  radix_e               radix_q, radix_d;
  logic                 lower_q, lower_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [CountW-1:0]    left_q, left_d;
  logic [ValueW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]      shreg_q, shreg_d;
  logic [ConvCycW-1:0]  conv_cnt_q, conv_cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharW-1:0]     out_char_q, out_char_d;
  logic [CountW-1:0]    out_pos_q, out_pos_d;
  logic                 out_last_q, out_last_d;
  logic                 load_ok;
  logic [3:0]           digit;

  assign load_ok = !out_valid_q || out_ready_i;
  assign digit   = (radix_q == RADIX_OCT) ? {1'b0, shreg_q[2:0]} : shreg_q[3:0];

  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    lower_d     = lower_q;
    count_d     = count_q;
    left_d      = left_q;
    bin_d       = bin_q;
    shreg_d     = shreg_q;
    conv_cnt_d  = conv_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          pop_o      = 1'b1;
          radix_d    = req_i.radix;
          lower_d    = req_i.lower;
          count_d    = req_i.count;
          left_d     = req_i.count;
          conv_cnt_d = '0;
          if (req_i.radix == RADIX_DEC) begin
            bin_d   = req_i.mag;
            shreg_d = '0;
            state_d = S_CONV;
          end else begin
            shreg_d = {{(BcdW-ValueW){1'b0}}, req_i.mag};
            state_d = S_EMIT;
          end
        end
      end
      S_CONV: begin
        // Two binary bits enter the BCD register per cycle, MSB first.
        shreg_d    = dd_step(dd_step(shreg_q, bin_q[ValueW-1]), bin_q[ValueW-2]);
        bin_d      = {bin_q[ValueW-3:0], 2'b00};
        conv_cnt_d = conv_cnt_q + 1'b1;
        if (conv_cnt_q == ConvLastCyc) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          if (left_q == '0) begin
            out_char_d = CharTerm;
            out_pos_d  = count_q;
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            out_char_d = digit_char(digit, lower_q);
            out_pos_d  = left_q - 1'b1;
            out_last_d = 1'b0;
            left_d     = left_q - 1'b1;
            shreg_d    = (radix_q == RADIX_OCT) ? (shreg_q >> 3) : (shreg_q >> 4);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      conv_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      conv_cnt_q  <= conv_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    lower_q    <= lower_d;
    count_q    <= count_d;
    bin_q      <= bin_d;
    shreg_q    <= shreg_d;
    out_char_q <= out_char_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;

  // A digit always lies inside the buffer of the request that produced it.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_pos_q < count_q)
    else $error("digit position outside the requested count");

  // Double dabble must leave only valid BCD digits.
  a_dec_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q && radix_q == RADIX_DEC |->
    out_char_q >= CharZero && out_char_q <= CharZero + 8'd9)
    else $error("decimal digit out of range");

  // The terminator follows right after the leftmost digit is taken.
  a_term_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !out_last_q && out_pos_q == '0 |=>
    out_valid_q && out_last_q)
    else $error("terminator did not follow the leftmost digit");

endmodule

// ----- test/tb_integer_to_ascii_digits.sv -----
// Self-checking testbench of the integer to ASCII digit converter.
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits;
  import i2a_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int DirN = 22;
  localparam int RandPerPhase = 65;
  localparam int TailCycles = 40;
  localparam string ByPredictor = "?";

  typedef struct packed {
    logic [1:0]        kind;
    logic [ValueW-1:0] val;
    logic [CountW-1:0] cnt;
    logic              lc;
  } req_row_t;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic [CountW-1:0] pos;
    logic              is_last;
  } out_char_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        req_type_i;
  logic [ValueW-1:0] value_i;
  logic [CountW-1:0] digit_count_i;
  logic              lower_case_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CharW-1:0]  character_o;
  logic [CountW-1:0] position_o;
  logic              last_o;

  out_char_t pending_chars[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  // Directed requests. Rows whose digits are spelled out are checked against
  // that text; the others go through the predictor.
  req_row_t dir_reqs [DirN] = '{
    '{ReqUdec, 64'd0,                  5'd1,  1'b0},
    '{ReqUdec, 64'hFFFF_FFFF_FFFF_FFFF, 5'd20, 1'b0},
    '{ReqUdec, 64'hFFFF_FFFF_FFFF_FFFF, 5'd22, 1'b1},
    '{ReqUdec, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b0},
    '{ReqUdec, 64'd12345,              5'd3,  1'b0},
    '{ReqUdec, 64'd12345,              5'd0,  1'b1},
    '{ReqSdec, 64'hFFFF_FFFF_FFFF_FFFF, 5'd4,  1'b0},
    '{ReqSdec, 64'h8000_0000_0000_0000, 5'd19, 1'b0},
    '{ReqSdec, 64'h7FFF_FFFF_FFFF_FFFF, 5'd19, 1'b1},
    '{ReqSdec, 64'hFFFF_FFFF_FFFF_CFC7, 5'd6,  1'b1},
    '{ReqOct,  64'hFFFF_FFFF_FFFF_FFFF, 5'd22, 1'b0},
    '{ReqOct,  64'd0,                  5'd22, 1'b1},
    '{ReqOct,  64'o777,                5'd0,  1'b0},
    '{ReqHex,  64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b0},
    '{ReqHex,  64'h0123_4567_89AB_CDEF, 5'd16, 1'b1},
    '{ReqHex,  64'h0123_4567_89AB_CDEF, 5'd16, 1'b0},
    '{ReqHex,  64'h0123_4567_89AB_CDEF, 5'd22, 1'b0},
    '{ReqHex,  64'hDEAD,               5'd2,  1'b1},
    '{ReqUdec, 64'h0000_0000_DEAD_BEEF, 5'd12, 1'b1},
    '{ReqSdec, 64'hFFFF_FFFF_0000_0000, 5'd21, 1'b0},
    '{ReqOct,  64'hA5A5_5A5A_A5A5_5A5A, 5'd17, 1'b1},
    '{ReqHex,  64'hFEDC_BA98_7654_3210, 5'd23, 1'b1}
  };

  string dir_digits [DirN] = '{
    "0",
    "18446744073709551615",
    "0018446744073709551615",
    "0018446744073709551615",
    "345",
    "",
    "0001",
    "9223372036854775808",
    "9223372036854775807",
    "012345",
    "1777777777777777777777",
    "0000000000000000000000",
    "",
    "FFFFFFFFFFFFFFFF",
    "0123456789abcdef",
    "0123456789ABCDEF",
    "0000000123456789ABCDEF",
    "ad",
    ByPredictor,
    ByPredictor,
    ByPredictor,
    ByPredictor
  };

  integer_to_ascii_digits dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .lower_case_i (lower_case_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .position_o   (position_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Digits of the request, least significant first, then the terminator.
  function automatic void predict_digits(input req_row_t r);
    logic [ValueW-1:0] quot;
    logic [ValueW-1:0] base;
    logic [ValueW-1:0] rem;
    logic [CountW-1:0] ndig;
    out_char_t         item;
    ndig = (r.cnt > MaxDigits) ? MaxDigits : r.cnt;
    quot = r.val;
    case (r.kind)
      ReqSdec: begin
        base = 64'd10;
        // Magnitude only; the most negative value wraps to 2^63 unsigned.
        if (r.val[ValueW-1]) begin
          quot = -r.val;
        end
      end
      ReqOct:  base = 64'd8;
      ReqHex:  base = 64'd16;
      default: base = 64'd10;
    endcase
    for (int p = int'(ndig) - 1; p >= 0; p--) begin
      rem = quot % base;
      if (rem < 64'd10) begin
        item.ch = "0" + rem[CharW-1:0];
      end else begin
        item.ch = (r.lc ? "a" : "A") + rem[CharW-1:0] - 8'd10;
      end
      item.pos = p[CountW-1:0];
      item.is_last = 1'b0;
      pending_chars.push_back(item);
      quot = quot / base;
    end
    item.ch = 8'h00;
    item.pos = ndig;
    item.is_last = 1'b1;
    pending_chars.push_back(item);
  endfunction

  // Presents one request and records what it must produce once it is taken.
  task automatic send_req(input req_row_t r, input string digits);
    out_char_t         item;
    logic [CountW-1:0] ndig;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= r.kind;
    value_i       <= r.val;
    digit_count_i <= r.cnt;
    lower_case_i  <= r.lc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (digits == ByPredictor) begin
      predict_digits(r);
    end else begin
      ndig = (r.cnt > MaxDigits) ? MaxDigits : r.cnt;
      for (int p = int'(ndig) - 1; p >= 0; p--) begin
        item.ch = digits[p];
        item.pos = p[CountW-1:0];
        item.is_last = 1'b0;
        pending_chars.push_back(item);
      end
      item.ch = 8'h00;
      item.pos = ndig;
      item.is_last = 1'b1;
      pending_chars.push_back(item);
    end
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    out_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction char=%h pos=%0d last=%b",
                                  character_o, position_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch) begin
          report_mismatch($sformatf("character %h, expected %h at pos %0d",
                                    character_o, want.ch, want.pos));
        end
        if (position_o !== want.pos) begin
          report_mismatch($sformatf("position %0d, expected %0d",
                                    position_o, want.pos));
        end
        if (last_o !== want.is_last) begin
          report_mismatch($sformatf("last %b, expected %b at pos %0d",
                                    last_o, want.is_last, want.pos));
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req_row_t rq;
    int       sel;
    int       phase_idle [4];
    int       phase_stall [4];
    phase_idle    = '{0, 80, 0, 8};
    phase_stall   = '{0, 0, 80, 8};
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    req_type_i    <= ReqUdec;
    value_i       <= '0;
    digit_count_i <= '0;
    lower_case_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirN; i++) begin
      send_req(dir_reqs[i], dir_digits[i]);
    end
    // Hold the sender back until every digit is out.
    drain_pending();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < RandPerPhase; n++) begin
        rq.kind = 2'($urandom_range(3));
        rq.lc = 1'($urandom_range(1));
        sel = $urandom_range(5);
        case (sel)
          0: rq.val = 64'($urandom_range(1000));
          1: rq.val = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(1000));
          2: rq.val = 64'd1 << $urandom_range(63);
          3: rq.val = {$urandom, $urandom} >> $urandom_range(63);
          default: rq.val = {$urandom, $urandom};
        endcase
        // Mostly in range, with some counts that must saturate.
        if ($urandom_range(7) == 0) begin
          rq.cnt = 5'($urandom_range(31, 23));
        end else begin
          rq.cnt = 5'($urandom_range(22));
        end
        send_req(rq, ByPredictor);
      end
      drain_pending();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/i2a_pkg.sv
hdl/i2a_front.sv
hdl/i2a_fifo.sv
hdl/i2a_back.sv
hdl/integer_to_ascii_digits.sv
test/tb_integer_to_ascii_digits.sv
